// ----- sv/ird_pkg.sv -----
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the indexed ring deque.
// ----------------------------------------------------------------------------
package ird_pkg;

  // largest supported capacity; logical positions are compared at this width
  localparam int MAX_CAPACITY   = 1024;
  localparam int PTR_W          = $clog2(MAX_CAPACITY + 1);

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 5;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic [PADDR_W-3:0] REG_CAP_LIMIT = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET    = 3'd0,
    FUNC_SET    = 3'd1,
    FUNC_INSERT = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SET,
    CELL_INS_FRONT,
    CELL_INS_BACK,
    CELL_REM_FRONT,
    CELL_REM_BACK
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e           op;
    logic [PTR_W-1:0]   pos;
    logic [PTR_W-1:0]   count;
  } cell_ctl_t;

endpackage

// ----- sv/ird_if.sv -----
// ----------------------------------------------------------------------------
// ird_in_if / ird_out_if
// Valid/ready channels carrying deque operations and their results.
// ----------------------------------------------------------------------------
interface ird_in_if #(
  parameter int DATA_WIDTH = ird_pkg::DEF_DATA_WIDTH
);
  import ird_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] write_data;

  modport source (output valid, func, position, write_data, input ready);
  modport sink   (input valid, func, position, write_data, output ready);
endinterface

interface ird_out_if #(
  parameter int DATA_WIDTH = ird_pkg::DEF_DATA_WIDTH
);
  import ird_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] read_data;
  logic [FILL_W-1:0]     fill_level;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, read_data, fill_level, status, input ready);
  modport sink   (input valid, read_data, fill_level, status, output ready);
endinterface

// ----- sv/indexed_ring_deque_unit.sv -----
// ----------------------------------------------------------------------------
// indexed_ring_deque_unit
// Bounded deque with access by position, built as a ring of element cells.
// ----------------------------------------------------------------------------
// For each operation (get, set, insert, remove, clear), the item is decoded
// against the head and fill registers, every cell of the ring updates in
// parallel from its neighbor or the write data, and the result lands in an
// output register. A new item is taken in every cycle in which the output
// register is empty or being drained, so the sustained rate is one item per
// cycle; the result is valid in the cycle after the item is accepted. The
// element store has no reset; capacity_limit (APB address 0) resets to 16 and
// may be written only while the block is idle.
module indexed_ring_deque_unit #(
  parameter int CAPACITY   = ird_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ird_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ird_pkg::PADDR_W-1:0]      paddr,
  input  logic [ird_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ird_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  ird_in_if.sink                           item_i,
  ird_out_if.source                        result_o
);
  import ird_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [LIMIT_W-1:0]    limit_q;
  logic [IW-1:0]         head_q;
  logic [IW-1:0]         head_d;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         count_d;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [FILL_W-1:0]     fill_q;
  status_e               status_q;
  status_e               status_d;

  logic                  accept;
  logic                  cfg_we;
  logic [PTR_W-1:0]      pos_x;
  logic [PTR_W-1:0]      cnt_x;
  logic [PTR_W-1:0]      lim_x;
  logic                  front;
  logic                  rd_en;
  cell_op_e              op;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   hit;
  logic [DATA_WIDTH-1:0] rd_mux;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_CAP_LIMIT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_CAP_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  // ---------------- handshake ----------------
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  // ---------------- decode ----------------
  always_comb begin
    pos_x = PTR_W'(item_i.position);
    cnt_x = PTR_W'(count_q);
    lim_x = (PTR_W'(limit_q) > PTR_W'(CAPACITY)) ? PTR_W'(CAPACITY) : PTR_W'(limit_q);
    front = pos_x < (cnt_x >> 1);

    op       = CELL_HOLD;
    head_d   = head_q;
    count_d  = count_q;
    status_d = STATUS_OK;
    rd_en    = 1'b0;

    unique case (item_i.func)
      FUNC_GET: begin
        if (pos_x < cnt_x) rd_en = 1'b1;
        else status_d = STATUS_RANGE;
      end
      FUNC_SET: begin
        if (pos_x < cnt_x) begin
          rd_en = 1'b1;
          op    = CELL_SET;
        end else begin
          status_d = STATUS_RANGE;
        end
      end
      FUNC_INSERT: begin
        if (pos_x > cnt_x) begin
          status_d = STATUS_RANGE;
        end else if (cnt_x >= lim_x) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CW'(1);
          if (front) begin
            op     = CELL_INS_FRONT;
            head_d = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
          end else begin
            op = CELL_INS_BACK;
          end
        end
      end
      FUNC_REMOVE: begin
        if (pos_x < cnt_x) begin
          rd_en   = 1'b1;
          count_d = count_q - CW'(1);
          if (front) begin
            op     = CELL_REM_FRONT;
            head_d = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
          end else begin
            op = CELL_REM_BACK;
          end
        end else begin
          status_d = STATUS_RANGE;
        end
      end
      FUNC_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: status_d = STATUS_RANGE;
    endcase

    ctl.op    = accept ? op : CELL_HOLD;
    ctl.pos   = pos_x;
    ctl.count = cnt_x;
  end

  // ---------------- ring of cells ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ird_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .head_i  (head_q),
      .ctl_i   (ctl),
      .wdata_i (item_i.write_data),
      .left_i  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
      .right_i (cell_data[(i + 1) % CAPACITY]),
      .data_o  (cell_data[i]),
      .hit_o   (hit[i])
    );
  end

  // at most one cell matches the position, so an OR of the gated words selects it
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_mux = rd_mux | (hit[i] ? cell_data[i] : '0);
    end
  end

  // ---------------- state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RST;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) limit_q <= pwdata[LIMIT_W-1:0];
      if (accept) begin
        head_q      <= head_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q  <= rd_en ? rd_mux : '0;
      fill_q   <= FILL_W'(count_d);
      status_q <= status_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.read_data  = rdata_q;
  assign result_o.fill_level = fill_q;
  assign result_o.status     = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.func == FUNC_CLEAR |=> count_q == '0 && head_q == '0)
    else $error("clear left elements behind");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.func == FUNC_INSERT && pos_x <= cnt_x && cnt_x >= lim_x
    |=> status_q == STATUS_FULL && $stable(count_q) && $stable(head_q))
    else $error("insert into full deque changed state");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.func != FUNC_CLEAR
    |=> count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
        || count_q + CW'(1) == $past(count_q))
    else $error("fill count moved by more than one");
`endif

endmodule

// ----- sv/ird_cell.sv -----
// ----------------------------------------------------------------------------
// ird_cell
// One physical slot of the ring: holds an element and takes a neighbor's value,
// the write data or keeps its own, depending on its logical position.
// ----------------------------------------------------------------------------
module ird_cell #(
  parameter int CAPACITY   = ird_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ird_pkg::DEF_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  logic                         clk_i,
  input  logic [$clog2(CAPACITY)-1:0]  head_i,
  input  ird_pkg::cell_ctl_t           ctl_i,
  input  logic [DATA_WIDTH-1:0]        wdata_i,
  input  logic [DATA_WIDTH-1:0]        left_i,
  input  logic [DATA_WIDTH-1:0]        right_i,
  output logic [DATA_WIDTH-1:0]        data_o,
  output logic                         hit_o
);
  import ird_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW:0] SLOT_W = (IW+1)'(INDEX);
  localparam logic [IW:0] CAP_W  = (IW+1)'(CAPACITY);

  logic [IW:0]           k_wide;
  logic [PTR_W-1:0]      k;
  logic [PTR_W-1:0]      kn;
  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  // logical index of this slot relative to the head
  always_comb begin
    if (SLOT_W >= {1'b0, head_i}) begin
      k_wide = SLOT_W - {1'b0, head_i};
    end else begin
      k_wide = SLOT_W + CAP_W - {1'b0, head_i};
    end
    k  = PTR_W'(k_wide);
    // logical index once the head has stepped back by one
    kn = (k == PTR_W'(CAPACITY - 1)) ? '0 : k + PTR_W'(1);
  end

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      CELL_HOLD: ;
      CELL_SET: begin
        if (k == ctl_i.pos) data_d = wdata_i;
      end
      CELL_INS_FRONT: begin
        if (kn < ctl_i.pos) begin
          data_d = right_i;
        end else if (kn == ctl_i.pos) begin
          data_d = wdata_i;
        end
      end
      CELL_INS_BACK: begin
        if (k == ctl_i.pos) begin
          data_d = wdata_i;
        end else if (k > ctl_i.pos && k <= ctl_i.count) begin
          data_d = left_i;
        end
      end
      CELL_REM_FRONT: begin
        if (k != '0 && k <= ctl_i.pos) data_d = left_i;
      end
      CELL_REM_BACK: begin
        if (k >= ctl_i.pos && k + PTR_W'(1) < ctl_i.count) data_d = right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (k == ctl_i.pos);

endmodule
